// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, muted while reset is asserted.
`define MTOP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also checks across reset.
`define MTOP_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mtop_pkg.sv =====
// Package: types and constants for the median threshold onset picker.
`timescale 1ns / 1ps
`default_nettype none
package mtop_pkg;

  // Field widths
  localparam int ODF_W   = 32;
  localparam int TIME_W  = 32;
  localparam int LEVEL_W = 31;
  localparam int GAP_W   = 20;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRE_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP    = 2'd1;

  localparam logic [LEVEL_W-1:0] FIRE_LEVEL_RST = 31'd9830400;
  localparam logic [GAP_W-1:0]   MIN_GAP_RST    = 20'd1200;

  // Stream payload widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_PICK,
    ST_DECIDE
  } state_t;

  // Strobes from the sequencer to every cell
  typedef struct packed {
    logic load;
    logic count;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/mtop_cell.sv =====
// One history cell: holds one sample and ranks it against the circulating ring.
`timescale 1ns / 1ps
`default_nettype none
module mtop_cell #(
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  mtop_pkg::cell_ctrl_t    ctrl,
  input  wire signed [31:0]       val_in,
  input  wire signed [31:0]       circ_in,
  output logic signed [31:0]      val_out,
  output logic signed [31:0]      circ_out,
  output logic                    hit
);
  import mtop_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int K     = (DEPTH / 2) + 1;

  logic signed [31:0] val_r, circ_r;
  logic [CNT_W-1:0]   lt_r, le_r;
  logic               lt_inc, le_inc;

  assign lt_inc = (circ_r < val_r);
  assign le_inc = (circ_r <= val_r);

  // History entry: shifts one place down on each finished item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (ctrl.shift) begin
      val_r <= val_in;
    end
  end

  // Ring copy and rank counters
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      circ_r <= val_r;
      lt_r   <= '0;
      le_r   <= '0;
    end else if (ctrl.count) begin
      circ_r <= circ_in;
      lt_r   <= lt_r + CNT_W'(lt_inc);
      le_r   <= le_r + CNT_W'(le_inc);
    end
  end

  // This entry sits at sorted position K when its rank interval covers K
  assign hit      = (lt_r <= CNT_W'(K)) && (le_r > CNT_W'(K));
  assign val_out  = val_r;
  assign circ_out = circ_r;

endmodule
`default_nettype wire

// ===== src/mtop_ctrl.sv =====
// Sequencer: load, rotate the ring, pick the median, decide and shift.
`timescale 1ns / 1ps
`default_nettype none
module mtop_ctrl #(
  parameter int DEPTH = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_fire,
  input  wire                    out_free,
  output logic                   in_ready,
  output logic                   pick,
  output mtop_pkg::cell_ctrl_t   ctrl
);
  import mtop_pkg::*;

  localparam int CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           last_rot;

  assign last_rot = (cnt_r == CW'(DEPTH - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        cnt_nxt = cnt_r + CW'(1);
        if (last_rot) state_nxt = ST_PICK;
      end
      ST_PICK: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    pick       = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.count = 1'b0;
    ctrl.shift = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_fire;
      end
      ST_COUNT:  ctrl.count = 1'b1;
      ST_PICK:   pick = 1'b1;
      ST_DECIDE: ctrl.shift = out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/median_threshold_onset_picker_top.sv =====
// Top level: median threshold onset picker built on a ring of history cells.
// Usage:
//   in_*   : one ODF sample and its frame timestamp per item.
//   out_*  : one result per item: onset flag and the local median.
//   cfg_*  : register writes (index 0 fire_level, 1 min_gap_frames); always ready.
// Sequence:
//   An accepted item loads the ring, which then rotates so each cell ranks
//   its sample against every other one; a pick step selects the median, and
//   a decide step forms the decision and loads the output register. The next
//   item is taken only once the decide step has finished and the block is
//   back in idle.
// Reset:
//   rst_n (synchronous, active low) zeroes the history and the last onset
//   time, loads the register defaults and empties the output register.
// Stall:
//   A result waits in the output register while out_tready is low; the next
//   item stops in its decide step and no other is taken until the result drains.
`timescale 1ns / 1ps
`default_nettype none
module median_threshold_onset_picker_top #(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // in_tdata: odf_value[31:0], frame_time[63:32]
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire [mtop_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata: onset_fire[0], median_value[32:1], zero pad[39:33]
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [mtop_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [mtop_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [mtop_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mtop_pkg::*;

  localparam int N = HISTORY_DEPTH;

  cell_ctrl_t          ctrl;
  logic                in_fire, out_free, pick;
  logic signed [31:0]  val_w  [N];
  logic signed [31:0]  circ_w [N];
  logic [N-1:0]        hit_w;
  logic signed [31:0]  med_or, med_r;
  logic signed [31:0]  sample_r;
  logic [TIME_W-1:0]   frame_r, last_r;
  logic [LEVEL_W-1:0]  fire_level_r;
  logic [GAP_W-1:0]    min_gap_r;
  logic                out_valid_r, out_fire_r;
  logic signed [31:0]  out_med_r;
  logic signed [32:0]  diff;
  logic [TIME_W-1:0]   elapsed;
  logic                fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  mtop_ctrl #(.DEPTH(N)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .in_ready (in_tready),
    .pick     (pick),
    .ctrl     (ctrl)
  );

  // Cell row: history shifts down, ring rotates down with wrap to the top
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [31:0] up_val;
    if (i == N - 1) begin : g_top
      assign up_val = sample_r;
    end else begin : g_mid
      assign up_val = val_w[i+1];
    end
    mtop_cell #(.DEPTH(N)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .val_in   (up_val),
      .circ_in  (circ_w[(i+1) % N]),
      .val_out  (val_w[i]),
      .circ_out (circ_w[i]),
      .hit      (hit_w[i])
    );
  end

  // Gather the selected entry; tied entries carry equal values
  always_comb begin
    med_or = '0;
    for (int i = 0; i < N; i++) begin
      med_or = med_or | (hit_w[i] ? val_w[i] : 32'sd0);
    end
  end

  // Input capture and median register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= $signed(in_tdata[31:0]);
      frame_r  <= in_tdata[63:32];
    end
    if (pick) med_r <= med_or;
  end

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fire_level_r <= FIRE_LEVEL_RST;
      min_gap_r    <= MIN_GAP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIRE_LEVEL: fire_level_r <= cfg_data[LEVEL_W-1:0];
        CFG_MIN_GAP:    min_gap_r    <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Onset decision
  assign diff    = {sample_r[31], sample_r} - {med_r[31], med_r};
  assign elapsed = frame_r - last_r;
  assign fire    = (diff >= $signed({2'b00, fire_level_r}))
                && (elapsed > {{(TIME_W-GAP_W){1'b0}}, min_gap_r});

  // Last onset time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (ctrl.shift && fire) begin
      last_r <= frame_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.shift) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      out_fire_r <= fire;
      out_med_r  <= med_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-33){1'b0}}, out_med_r, out_fire_r};

endmodule
`default_nettype wire

// ===== src/mtop_checker.sv =====
// Port-level checker for the onset picker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mtop_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_tvalid,
  input wire                                in_tready,
  input wire [mtop_pkg::IN_DATA_W-1:0]      in_tdata,
  input wire                                out_tvalid,
  input wire                                out_tready,
  input wire [mtop_pkg::OUT_DATA_W-1:0]     out_tdata,
  input wire                                cfg_valid,
  input wire                                cfg_ready,
  input wire [mtop_pkg::CFG_IDX_W-1:0]      cfg_index,
  input wire [mtop_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // A held result keeps its value
  `MTOP_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // One item at a time: busy right after an accept
  `MTOP_ASSERT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "second item taken while busy")

  // No result can appear the cycle after an accept into an empty output
  `MTOP_ASSERT(a_no_instant_result, clk, rst_n, in_tvalid && in_tready && !out_tvalid |=> !out_tvalid, "result appeared too early")

  // Reset empties the output register
  `MTOP_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

  // Pad bits of the result stay zero
  `MTOP_ASSERT(a_pad_zero, clk, rst_n, out_tvalid |-> out_tdata[39:33] == 7'd0, "result pad bits set")

endmodule

bind median_threshold_onset_picker_top mtop_checker u_mtop_checker (.*);
`default_nettype wire

// ===== bench/median_threshold_onset_picker_top_tb.sv =====
// Testbench for the onset picker: scripted and random hops checked against a predictor.
`timescale 1ns / 1ps
module median_threshold_onset_picker_top_tb;
  import mtop_pkg::*;

  localparam int DEPTH = 16;
  localparam int MEDIAN_RANK = DEPTH / 2 + 1;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 2 * (DEPTH + 3);
  localparam int PHASES = 6;
  localparam int HOPS_PER_PHASE = 100;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum logic {ROW_HOP, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] odf;
    logic [31:0] ft;
    logic [1:0]  idx;
    logic [31:0] data;
    logic        typed;
    logic        fire;
    logic [31:0] median;
  } script_row_t;

  typedef struct packed {
    logic        fire;
    logic [31:0] median;
  } onset_t;

  // Directed script: kind, odf, frame, reg index, reg data, typed, fire, median
  localparam int N_ROWS = 28;
  localparam script_row_t SCRIPT [N_ROWS] = '{
    // defaults after reset: exactly at the level, gap one past the minimum
    '{ROW_HOP, 32'd9830400,    32'd1201,       2'd0, 32'd0, 1'b1, 1'b1, 32'd0},
    // gap exactly equal to the minimum does not fire
    '{ROW_HOP, 32'd9830400,    32'd2401,       2'd0, 32'd0, 1'b1, 1'b0, 32'd0},
    // one LSB under the level
    '{ROW_HOP, 32'd9830399,    32'd5000,       2'd0, 32'd0, 1'b1, 1'b0, 32'd0},
    '{ROW_HOP, 32'h7FFF_FFFF,  32'hFFFF_FFFF,  2'd0, 32'd0, 1'b1, 1'b1, 32'd0},
    '{ROW_HOP, 32'h8000_0000,  32'h0000_0000,  2'd0, 32'd0, 1'b1, 1'b0, 32'd0},
    // frame counter wraps past the last onset
    '{ROW_HOP, 32'h7FFF_FFFF,  32'd5,          2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    // bits above each register width are dropped
    '{ROW_CFG, 32'd0, 32'd0, CFG_FIRE_LEVEL, 32'h8000_0000, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG, 32'd0, 32'd0, CFG_MIN_GAP,    32'hFFF0_0000, 1'b0, 1'b0, 32'd0},
    // writes to unused indexes change nothing
    '{ROW_CFG, 32'd0, 32'd0, CFG_SPARE_2,    32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG, 32'd0, 32'd0, CFG_SPARE_3,    32'h0000_0001, 1'b0, 1'b0, 32'd0},
    '{ROW_HOP, 32'd0,          32'd5,          2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_HOP, 32'd0,          32'd5,          2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG, 32'd0, 32'd0, CFG_FIRE_LEVEL, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG, 32'd0, 32'd0, CFG_MIN_GAP,    32'h000F_FFFF, 1'b0, 1'b0, 32'd0},
    // pull the median down to the most negative value
    '{ROW_HOP, 32'h8000_0000,  32'd100,        2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_HOP, 32'h8000_0000,  32'd200,        2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_HOP, 32'h8000_0000,  32'd300,        2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_HOP, 32'h8000_0000,  32'd400,        2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_HOP, 32'h8000_0000,  32'd500,        2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_HOP, 32'h8000_0000,  32'd600,        2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_HOP, 32'h8000_0000,  32'd700,        2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_HOP, 32'h8000_0000,  32'd800,        2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_HOP, 32'h8000_0000,  32'd900,        2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_HOP, 32'h8000_0000,  32'd1000,       2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    // widest difference against the largest level
    '{ROW_HOP, 32'h7FFF_FFFF,  32'h0020_0000,  2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    // timestamp earlier than the last onset reads as a huge gap
    '{ROW_HOP, 32'h7FFF_FFFF,  32'h0010_0000,  2'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG, 32'd0, 32'd0, CFG_FIRE_LEVEL, {1'b0, FIRE_LEVEL_RST}, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG, 32'd0, 32'd0, CFG_MIN_GAP,    {12'd0, MIN_GAP_RST},   1'b0, 1'b0, 32'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tready;
  logic out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_ready;

  // Predictor state
  logic signed [31:0] odf_hist [DEPTH];
  logic [31:0] last_onset;
  logic [LEVEL_W-1:0] fire_lvl;
  logic [GAP_W-1:0] min_gap;
  onset_t pending_onsets [$];

  int mismatches = 0;
  int stall_cycles = 0;
  bit hold_req = 1'b0;
  int rx_hold_left = 0;
  int rx_seg_left = 0;
  int rx_seg_mode = 0;

  median_threshold_onset_picker_top #(
    .HISTORY_DEPTH(DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Order statistic of the current history
  function automatic logic [31:0] local_median();
    logic signed [31:0] srt [DEPTH];
    logic signed [31:0] key;
    int i;
    int j;
    srt = odf_hist;
    for (i = 1; i < DEPTH; i++) begin
      key = srt[i];
      j = i - 1;
      while (j >= 0 && srt[j] > key) begin
        srt[j + 1] = srt[j];
        j--;
      end
      srt[j + 1] = key;
    end
    return srt[MEDIAN_RANK];
  endfunction

  // Decide one hop and advance the history
  function automatic onset_t pick_onset(input logic [31:0] odf, input logic [31:0] ft);
    onset_t r;
    longint margin;
    logic [31:0] elapsed;
    int i;
    r.median = local_median();
    margin = longint'($signed(odf)) - longint'($signed(r.median));
    elapsed = ft - last_onset;
    r.fire = (margin >= longint'(fire_lvl)) && (elapsed > {12'd0, min_gap});
    if (r.fire) last_onset = ft;
    for (i = 0; i < DEPTH - 1; i++) odf_hist[i] = odf_hist[i + 1];
    odf_hist[DEPTH - 1] = odf;
    return r;
  endfunction

  // Offer one hop; valid stays high on return
  task automatic send_hop(input logic [31:0] odf, input logic [31:0] ft, input logic typed,
                          input logic t_fire, input logic [31:0] t_median);
    onset_t exp_r;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {ft, odf};
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    exp_r = pick_onset(odf, ft);
    if (typed) begin
      exp_r.fire = t_fire;
      exp_r.median = t_median;
    end
    pending_onsets.push_back(exp_r);
  endtask

  // Drop valid and wait until every result is back
  task automatic go_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_onsets.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      CFG_FIRE_LEVEL: fire_lvl = data[LEVEL_W-1:0];
      CFG_MIN_GAP:    min_gap = data[GAP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver: random segments of stall patterns, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && rx_hold_left == 0) begin
      rx_hold_left = HOLD_OFF_CYCLES;
      hold_req = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready = 1'b0;
    end else begin
      if (rx_seg_left == 0) begin
        rx_seg_mode = $urandom_range(0, 3);
        rx_seg_left = $urandom_range(1, 40);
      end
      rx_seg_left--;
      case (rx_seg_mode)
        0:       out_tready = 1'b1;
        1:       out_tready = $urandom_range(0, 1);
        2:       out_tready = ($urandom_range(0, 3) == 0);
        default: out_tready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Result check and watchdog
  always @(posedge clk) begin
    onset_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_onsets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: unexpected result %h", out_tdata);
      end else begin
        exp_r = pending_onsets.pop_front();
        if (out_tdata[0] !== exp_r.fire || out_tdata[32:1] !== exp_r.median ||
            out_tdata[39:33] !== 7'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("MISMATCH: fire exp %b got %b, median exp %h got %h, pad %h",
                     exp_r.fire, out_tdata[0], exp_r.median, out_tdata[32:1],
                     out_tdata[39:33]);
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("median_threshold_onset_picker_top_tb failed");
      $finish;
    end
  end

  initial begin
    script_row_t row;
    logic [31:0] ft_now;
    logic [31:0] odf_v;
    logic [31:0] lvl_v;
    logic [31:0] gap_v;
    longint aim;
    int r;
    int ph;
    int sent;
    int burst;
    int k;
    int gap;
    foreach (odf_hist[i]) odf_hist[i] = '0;
    last_onset = '0;
    fire_lvl = FIRE_LEVEL_RST;
    min_gap = MIN_GAP_RST;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed script
    for (r = 0; r < N_ROWS; r++) begin
      row = SCRIPT[r];
      if (row.kind == ROW_CFG) begin
        go_idle();
        write_reg(row.idx, row.data);
      end else begin
        send_hop(row.odf, row.ft, row.typed, row.fire, row.median);
      end
    end

    // Random phases, each under its own register setting
    ft_now = $urandom;
    for (ph = 0; ph < PHASES; ph++) begin
      go_idle();
      case (ph)
        0: begin lvl_v = 32'd0;         gap_v = 32'd0; end
        1: begin lvl_v = 32'hFFFF_FFFF; gap_v = 32'hFFFF_FFFF; end
        2: begin
          lvl_v = {1'b1, FIRE_LEVEL_RST};
          gap_v = ($urandom & 32'hFFF0_0000) | {12'd0, MIN_GAP_RST};
        end
        3: begin lvl_v = $urandom_range(0, 32'h00FF_FFFF); gap_v = $urandom_range(0, 2000); end
        4: begin lvl_v = $urandom;                         gap_v = $urandom; end
        default: begin lvl_v = $urandom_range(0, 32'h0010_0000); gap_v = $urandom_range(0, 300); end
      endcase
      write_reg(CFG_FIRE_LEVEL, lvl_v);
      write_reg(CFG_MIN_GAP, gap_v);
      if (ph == 2) hold_req = 1'b1;

      sent = 0;
      while (sent < HOPS_PER_PHASE) begin
        burst = $urandom_range(1, 12);
        for (k = 0; k < burst; k++) begin
          // mostly ordinary hop spacing, now and then a jump anywhere
          if ($urandom_range(0, 15) == 0) ft_now = $urandom;
          else ft_now = ft_now + $urandom_range(1, 600);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: odf_v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            6, 7: begin
              // spike near the firing threshold
              aim = longint'($signed(local_median())) + longint'(fire_lvl)
                    + longint'($urandom_range(0, 2)) - 1;
              if (aim > 64'sd2147483647) aim = 64'sd2147483647;
              odf_v = aim[31:0];
            end
            8: odf_v = $urandom;
            default: odf_v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          endcase
          send_hop(odf_v, ft_now, 1'b0, 1'b0, 32'd0);
          sent++;
        end
        gap = $urandom_range(0, 25);
        if (gap > 8) begin
          @(negedge clk);
          in_tvalid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end

    go_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("median_threshold_onset_picker_top_tb passed");
    end else begin
      $display("median_threshold_onset_picker_top_tb failed");
    end
    $finish;
  end

endmodule
